[design/srx_pkg.sv]
// Package for the symbol rewrite expander: default sizes, command codes
// and the controller state type. No dependencies.
`default_nettype none

package srx_pkg;

  localparam int unsigned SRX_NUM_RULES   = 8;
  localparam int unsigned SRX_MAX_REPLACE = 16;
  localparam int unsigned SRX_SYMBOL_BITS = 16;

  // Fixed field widths of the ports
  localparam int unsigned SRX_CMD_W   = 2;
  localparam int unsigned SRX_RIDX_W  = 3;
  localparam int unsigned SRX_POS_W   = 4;
  localparam int unsigned SRX_SYM_W   = 16;
  localparam int unsigned SRX_LEN_W   = 5;
  localparam int unsigned SRX_COUNT_W = 4;

  typedef enum logic [SRX_CMD_W-1:0] {
    CMD_RULE    = 2'd0,
    CMD_REPL    = 2'd1,
    CMD_REWRITE = 2'd2,
    CMD_NOP     = 2'd3
  } srx_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PASS,
    ST_EMIT
  } srx_state_e;

endpackage

`default_nettype wire

[design/symbol_rewrite_expander.sv]
// Top level of the symbol rewrite expander: rule table and replacement
// store in two srx_ram instances, scan/emit controller, output register.
// Depends on srx_pkg and srx_ram.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_stall_o | command, rule_index, position, symbol,
//          |           |                         | length
//  out     | output    | out_valid_o/out_stall_i | out_symbol, last, from_rule
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (rule_count)
//
// Load commands and the unused command are handled in idle without leaving it.
// A rewrite reads the rule table one entry at a time through the single read port, from
// rule 0 up to the first matching rule, or through every active rule on a miss. It then
// streams one replacement read per cycle while the output is not stalled, each read held
// in the RAM register before it moves to the output register; it emits nothing for an
// empty replacement, or hands over a passthrough symbol. Output stalls hold the stream.
// Reset clears control state only; table contents are undefined until loaded.
// in_stall_o is low whenever the controller is idle, even while a result waits in the
// output register.
`default_nettype none

module symbol_rewrite_expander
  import srx_pkg::*;
#(
  parameter int unsigned NUM_RULES   = SRX_NUM_RULES,
  parameter int unsigned MAX_REPLACE = SRX_MAX_REPLACE,
  parameter int unsigned SYMBOL_BITS = SRX_SYMBOL_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [SRX_CMD_W-1:0]   command_i,
  input  wire logic [SRX_RIDX_W-1:0]  rule_index_i,
  input  wire logic [SRX_POS_W-1:0]   position_i,
  input  wire logic [SRX_SYM_W-1:0]   symbol_i,
  input  wire logic [SRX_LEN_W-1:0]   length_i,

  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [SRX_SYM_W-1:0]   out_symbol_o,
  output logic                        last_o,
  output logic                        from_rule_o,

  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [SRX_COUNT_W-1:0] cfg_data_i
);

  localparam int unsigned SW   = (SYMBOL_BITS < SRX_SYM_W) ? SYMBOL_BITS : SRX_SYM_W;
  localparam int unsigned LW   = $clog2(MAX_REPLACE + 1);
  localparam int unsigned RIW  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int unsigned ACW  = $clog2(NUM_RULES + 1);
  localparam int unsigned REPD = NUM_RULES * MAX_REPLACE;
  localparam int unsigned RAW  = (REPD > 1) ? $clog2(REPD) : 1;

  srx_state_e state_q, state_d;

  logic [ACW-1:0]         r_q, r_d, r_next, active;
  logic [SW-1:0]          sym_q, sym_d;
  logic [LW-1:0]          n_q, n_d, k_q, k_d, k_next;
  logic [RAW-1:0]         base_q, base_d;
  logic                   dval_q, dval_d, dlast_q, dlast_d;
  logic                   out_valid_q, out_valid_d;
  logic [SRX_SYM_W-1:0]   out_sym_q, out_sym_d;
  logic                   out_last_q, out_last_d, out_rule_q, out_rule_d;
  logic [SRX_COUNT_W-1:0] rule_count_q, rule_count_d;

  logic                   accept, out_free, load_out, issue;
  logic [LW-1:0]          len_clamped;

  // Rule table: {length, match symbol}
  logic                   rule_we, rule_re;
  logic [RIW-1:0]         rule_waddr, rule_raddr;
  logic [LW+SW-1:0]       rule_wdata, rule_rdata;
  logic [LW-1:0]          rd_len;
  logic [SW-1:0]          rd_match;

  logic                   rep_we, rep_re;
  logic [RAW-1:0]         rep_waddr, rep_raddr;
  logic [SW-1:0]          rep_rdata;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign len_clamped = LW'((32'(length_i) > MAX_REPLACE) ? MAX_REPLACE : 32'(length_i));
  assign active      = (32'(rule_count_q) > NUM_RULES) ? ACW'(NUM_RULES)
                                                       : ACW'(rule_count_q);

  // Table writes happen only on an accept in idle, reads only on a rewrite accept or while
  // busy, so the same entry is never written and read in one cycle.
  assign rule_we    = accept && (command_i == CMD_RULE) && (32'(rule_index_i) < NUM_RULES);
  assign rule_waddr = RIW'(rule_index_i);
  assign rule_wdata = {len_clamped, symbol_i[SW-1:0]};
  assign {rd_len, rd_match} = rule_rdata;

  assign rep_we    = accept && (command_i == CMD_REPL) &&
                     (32'(rule_index_i) < NUM_RULES) && (32'(position_i) < MAX_REPLACE);
  assign rep_waddr = RAW'(32'(rule_index_i) * MAX_REPLACE + 32'(position_i));
  assign rep_raddr = base_q + RAW'(k_q);

  assign r_next   = r_q + 1'b1;
  assign k_next   = k_q + 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == ST_EMIT) && dval_q && out_free;
  assign issue    = (state_q == ST_EMIT) && (k_q != n_q) && (!dval_q || load_out);

  srx_ram #(
    .Width(LW + SW),
    .Depth(NUM_RULES)
  ) u_rule_ram (
    .clk_i  (clk_i),
    .we_i   (rule_we),
    .waddr_i(rule_waddr),
    .wdata_i(rule_wdata),
    .re_i   (rule_re),
    .raddr_i(rule_raddr),
    .rdata_o(rule_rdata)
  );

  srx_ram #(
    .Width(SW),
    .Depth(REPD)
  ) u_rep_ram (
    .clk_i  (clk_i),
    .we_i   (rep_we),
    .waddr_i(rep_waddr),
    .wdata_i(symbol_i[SW-1:0]),
    .re_i   (rep_re),
    .raddr_i(rep_raddr),
    .rdata_o(rep_rdata)
  );

  always_comb begin
    state_d      = state_q;
    r_d          = r_q;
    sym_d        = sym_q;
    n_d          = n_q;
    k_d          = k_q;
    base_d       = base_q;
    dval_d       = dval_q;
    dlast_d      = dlast_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_sym_d    = out_sym_q;
    out_last_d   = out_last_q;
    out_rule_d   = out_rule_q;
    rule_count_d = cfg_valid_i ? cfg_data_i : rule_count_q;
    rule_re      = 1'b0;
    rule_raddr   = '0;
    rep_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (command_i == CMD_REWRITE)) begin
          sym_d = symbol_i[SW-1:0];
          r_d   = '0;
          if (active != '0) begin
            rule_re = 1'b1;
            state_d = ST_SCAN;
          end else begin
            state_d = ST_PASS;
          end
        end
      end
      ST_SCAN: begin
        if (rd_match == sym_q) begin
          n_d     = rd_len;
          k_d     = '0;
          base_d  = RAW'(32'(r_q) * MAX_REPLACE);
          dval_d  = 1'b0;
          state_d = (rd_len == '0) ? ST_IDLE : ST_EMIT;
        end else if (r_next < active) begin
          rule_re    = 1'b1;
          rule_raddr = r_next[RIW-1:0];
          r_d        = r_next;
        end else begin
          state_d = ST_PASS;
        end
      end
      ST_PASS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = SRX_SYM_W'(sym_q);
          out_last_d  = 1'b1;
          out_rule_d  = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // Stream: read slot k while the previous slot moves to the output.
        if (load_out) begin
          out_valid_d = 1'b1;
          out_sym_d   = SRX_SYM_W'(rep_rdata);
          out_last_d  = dlast_q;
          out_rule_d  = 1'b1;
          if (dlast_q) begin
            state_d = ST_IDLE;
          end
        end
        if (issue) begin
          rep_re  = 1'b1;
          k_d     = k_next;
          dlast_d = (k_next == n_q);
        end
        dval_d = issue || (dval_q && !load_out);
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      dval_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      rule_count_q <= '0;
    end else begin
      state_q      <= state_d;
      dval_q       <= dval_d;
      out_valid_q  <= out_valid_d;
      rule_count_q <= rule_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    sym_q      <= sym_d;
    n_q        <= n_d;
    k_q        <= k_d;
    base_q     <= base_d;
    dlast_q    <= dlast_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
    out_rule_q <= out_rule_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign last_o       = out_last_q;
  assign from_rule_o  = out_rule_q;

  a_dval_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dval_q |-> (state_q == ST_EMIT))
    else $error("replacement data held outside emit");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (k_q <= n_q))
    else $error("more replacement reads issued than the rule length");

  a_pass_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !from_rule_o) |-> last_o)
    else $error("passthrough result not marked last");

  a_rewrite_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (command_i == CMD_REWRITE)) |=> in_stall_o)
    else $error("rewrite transfer did not start the scan");

endmodule

`default_nettype wire

[design/srx_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued. No dependencies.
`default_nettype none

module srx_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[tb/sv/srx_emit_checker.sv]
// Checker for the symbol rewrite expander: watches the input, output and
// configuration channels, predicts the emitted stream and compares it.
// Depends on srx_pkg.
`timescale 1ns / 100ps

module srx_emit_checker
  import srx_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   in_valid_i,
  input  wire logic                   in_stall_i,
  input  wire logic [SRX_CMD_W-1:0]   command_i,
  input  wire logic [SRX_RIDX_W-1:0]  rule_index_i,
  input  wire logic [SRX_POS_W-1:0]   position_i,
  input  wire logic [SRX_SYM_W-1:0]   symbol_i,
  input  wire logic [SRX_LEN_W-1:0]   length_i,

  input  wire logic                   out_valid_i,
  input  wire logic                   out_stall_i,
  input  wire logic [SRX_SYM_W-1:0]   out_symbol_i,
  input  wire logic                   last_i,
  input  wire logic                   from_rule_i,

  input  wire logic                   cfg_valid_i,
  input  wire logic                   cfg_ready_i,
  input  wire logic [SRX_COUNT_W-1:0] cfg_data_i,

  output int                          mismatches_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [SRX_SYM_W-1:0] symbol;
    logic                 last;
    logic                 from_rule;
  } emitted_t;

  logic [SRX_COUNT_W-1:0] rule_count_q;
  logic [SRX_SYM_W-1:0]   match_tab  [SRX_NUM_RULES];
  logic [SRX_LEN_W-1:0]   length_tab [SRX_NUM_RULES];
  logic [SRX_SYM_W-1:0]   repl_tab   [SRX_NUM_RULES*SRX_MAX_REPLACE];
  emitted_t               emitted_q  [$];
  int                     mismatches;

  // Apply one accepted command to the shadow tables and queue what it emits.
  task automatic rewrite_item(input srx_cmd_e cmd, input logic [SRX_RIDX_W-1:0] ri,
                              input logic [SRX_POS_W-1:0] pos,
                              input logic [SRX_SYM_W-1:0] sym,
                              input logic [SRX_LEN_W-1:0] len);
    int  active;
    int  n;
    bit  hit;
    case (cmd)
      CMD_RULE: begin
        if (int'(ri) < SRX_NUM_RULES) begin
          match_tab[ri]  = sym;
          length_tab[ri] = (int'(len) > SRX_MAX_REPLACE) ? SRX_LEN_W'(SRX_MAX_REPLACE) : len;
        end
      end
      CMD_REPL: begin
        if (int'(ri) < SRX_NUM_RULES && int'(pos) < SRX_MAX_REPLACE)
          repl_tab[int'(ri) * SRX_MAX_REPLACE + int'(pos)] = sym;
      end
      CMD_REWRITE: begin
        active = (int'(rule_count_q) > SRX_NUM_RULES) ? SRX_NUM_RULES : int'(rule_count_q);
        hit = 1'b0;
        for (int r = 0; r < active && !hit; r++) begin
          if (match_tab[r] == sym) begin
            hit = 1'b1;
            n = int'(length_tab[r]);
            for (int k = 0; k < n; k++)
              emitted_q.push_back({repl_tab[r * SRX_MAX_REPLACE + k], k == n - 1, 1'b1});
          end
        end
        // no rule took it: pass the symbol through
        if (!hit) emitted_q.push_back({sym, 1'b1, 1'b0});
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    emitted_t got;
    emitted_t want;
    if (!rst_ni) begin
      rule_count_q = '0;
      emitted_q.delete();
      mismatches   = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        rewrite_item(srx_cmd_e'(command_i), rule_index_i, position_i, symbol_i, length_i);
      if (cfg_valid_i && cfg_ready_i) rule_count_q = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        got = {out_symbol_i, last_i, from_rule_i};
        if (emitted_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer: expected none, actual symbol=%h last=%b %s%b",
                   $time, got.symbol, got.last, "from_rule=", got.from_rule);
        end else begin
          want = emitted_q.pop_front();
          if (got.symbol !== want.symbol || got.last !== want.last ||
              got.from_rule !== want.from_rule) begin
            mismatches++;
            $display("%0t: mismatch: expected symbol=%h last=%b from_rule=%b, %s%h %s%b %s%b",
                     $time, want.symbol, want.last, want.from_rule,
                     "actual symbol=", got.symbol, "last=", got.last,
                     "from_rule=", got.from_rule);
          end
        end
      end
      mismatches_o <= mismatches;
      pending_o    <= emitted_q.size();
    end
  end

endmodule

[tb/sv/tb_symbol_rewrite_expander.sv]
// Testbench top for the symbol rewrite expander: clock, reset, stimulus,
// output back-pressure and the verdict. Depends on srx_pkg, srx_emit_checker and the block.
`timescale 1ns / 100ps

module tb_symbol_rewrite_expander;
  import srx_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 430;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;

  logic                   in_valid   = 1'b0;
  wire                    in_stall;
  logic [SRX_CMD_W-1:0]   command    = '0;
  logic [SRX_RIDX_W-1:0]  rule_index = '0;
  logic [SRX_POS_W-1:0]   position   = '0;
  logic [SRX_SYM_W-1:0]   symbol     = '0;
  logic [SRX_LEN_W-1:0]   length     = '0;

  wire                    out_valid;
  logic                   out_stall  = 1'b0;
  wire  [SRX_SYM_W-1:0]   out_symbol;
  wire                    last;
  wire                    from_rule;

  logic                   cfg_valid  = 1'b0;
  wire                    cfg_ready;
  logic [SRX_COUNT_W-1:0] cfg_data   = '0;

  int                     checker_errors;
  int                     open_results;

  // stimulus-side bookkeeping: which rules are fully loaded and what they match
  bit                     rule_ready [SRX_NUM_RULES];
  logic [SRX_SYM_W-1:0]   rule_match [SRX_NUM_RULES];
  logic [SRX_SYM_W-1:0]   sym_pool   [4];
  int                     sent_items = 0;
  logic                   calm       = 1'b0;
  logic                   squeeze    = 1'b0;
  int                     quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  symbol_rewrite_expander u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (command),
    .rule_index_i (rule_index),
    .position_i   (position),
    .symbol_i     (symbol),
    .length_i     (length),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_symbol_o (out_symbol),
    .last_o       (last),
    .from_rule_o  (from_rule),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  srx_emit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .command_i    (command),
    .rule_index_i (rule_index),
    .position_i   (position),
    .symbol_i     (symbol),
    .length_i     (length),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_symbol_i (out_symbol),
    .last_i       (last),
    .from_rule_i  (from_rule),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .mismatches_o (checker_errors),
    .pending_o    (open_results)
  );

  // Receiver: random stalls, one long hold on request, none while calm.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int  hold_left;
    bit  hold_done;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (squeeze && !hold_done) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 20);
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item after a random gap; valid stays high until the next call decides.
  task automatic send_item(input srx_cmd_e cmd, input logic [SRX_RIDX_W-1:0] ri,
                           input logic [SRX_POS_W-1:0] pos,
                           input logic [SRX_SYM_W-1:0] sym,
                           input logic [SRX_LEN_W-1:0] len);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    rule_index <= ri;
    position   <= pos;
    symbol     <= sym;
    length     <= len;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (cmd != CMD_NOP) sent_items++;
  endtask

  // Offer one item whose fields besides the command are all random.
  task automatic send_random(input srx_cmd_e cmd);
    send_item(cmd, SRX_RIDX_W'($urandom), SRX_POS_W'($urandom), SRX_SYM_W'($urandom),
              SRX_LEN_W'($urandom));
  endtask

  // Drop valid, wait for every expected result, then let the block finish silent work.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (open_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rule_count(input logic [SRX_COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Write match and length, then every slot the length makes readable.
  task automatic load_rule(input int r);
    logic [SRX_SYM_W-1:0] sym;
    int len;
    int eff;
    int pick;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) sym = SRX_SYM_W'($urandom);
    else sym = sym_pool[$urandom_range(3)];
    if (pick < 60) len = $urandom_range(3);
    else if (pick < 80) len = $urandom_range(8, 4);
    else if (pick < 90) len = SRX_MAX_REPLACE;
    else len = $urandom_range(31, 17);
    send_item(CMD_RULE, SRX_RIDX_W'(r), SRX_POS_W'($urandom), sym, SRX_LEN_W'(len));
    eff = (len > SRX_MAX_REPLACE) ? SRX_MAX_REPLACE : len;
    for (int k = 0; k < eff; k++)
      send_item(CMD_REPL, SRX_RIDX_W'(r), SRX_POS_W'(k), SRX_SYM_W'($urandom),
                SRX_LEN_W'($urandom));
    rule_match[r] = sym;
    rule_ready[r] = 1'b1;
  endtask

  // Ignored commands, stray slot writes and half-loaded rules outside the active range.
  task automatic noise_item(input int active);
    int r;
    case ($urandom_range(3))
      0: send_random(CMD_NOP);
      1: send_random(CMD_REPL);
      default: begin
        if (active < SRX_NUM_RULES) begin
          r = $urandom_range(SRX_NUM_RULES - 1, active);
          send_item(CMD_RULE, SRX_RIDX_W'(r), SRX_POS_W'($urandom), SRX_SYM_W'($urandom),
                    SRX_LEN_W'($urandom));
          rule_ready[r] = 1'b0;
          repeat ($urandom_range(2))
            send_item(CMD_REPL, SRX_RIDX_W'(r), SRX_POS_W'($urandom), SRX_SYM_W'($urandom),
                      SRX_LEN_W'($urandom));
        end else begin
          send_random(CMD_NOP);
        end
      end
    endcase
  endtask

  initial begin : stimulus
    int phase;
    int count;
    int active;
    int target;
    int pick;
    logic [SRX_SYM_W-1:0] sym;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rule_count is zero out of reset: everything passes through
    send_item(CMD_REWRITE, 3'd5, 4'd9, 16'h0000, 5'd3);
    send_item(CMD_REWRITE, 3'd2, 4'd6, 16'hFFFF, 5'd30);
    send_item(CMD_NOP, 3'd7, 4'd15, 16'hFFFF, 5'd31);
    send_item(CMD_RULE, 3'd0, 4'd15, 16'h0000, 5'd0);
    send_item(CMD_RULE, 3'd1, 4'd0, 16'hFFFF, 5'd2);
    send_item(CMD_REPL, 3'd1, 4'd0, 16'hFFFF, 5'd31);
    send_item(CMD_REPL, 3'd1, 4'd1, 16'h0000, 5'd0);
    send_item(CMD_REPL, 3'd7, 4'd15, 16'h5AA5, 5'd16);
    send_item(CMD_REWRITE, 3'd7, 4'd15, 16'h8001, 5'd31);
    settle();
    write_rule_count(4'd2);
    // zero-length rule, two-symbol rule, miss over both rules
    send_item(CMD_REWRITE, 3'd0, 4'd0, 16'h0000, 5'd0);
    send_item(CMD_REWRITE, 3'd3, 4'd12, 16'hFFFF, 5'd17);
    send_item(CMD_REWRITE, 3'd6, 4'd3, 16'h1234, 5'd8);
    send_item(CMD_NOP, 3'd0, 4'd0, 16'h0000, 5'd0);
    settle();
    write_rule_count(4'd1);
    // rule one is now outside the active range
    send_item(CMD_REWRITE, 3'd1, 4'd1, 16'hFFFF, 5'd1);
    send_item(CMD_REWRITE, 3'd4, 4'd10, 16'h0000, 5'd20);

    for (int r = 0; r < SRX_NUM_RULES; r++) rule_ready[r] = 1'b0;
    rule_ready[0] = 1'b1;
    rule_match[0] = 16'h0000;
    rule_ready[1] = 1'b1;
    rule_match[1] = 16'hFFFF;

    target = sent_items + RANDOM_ITEMS;
    phase = 0;
    while (sent_items < target) begin
      settle();
      case (phase)
        0:       count = 8;
        1:       count = 15;
        2:       count = 3;
        3:       count = 0;
        4:       count = 1;
        5:       count = 9;
        default: count = $urandom_range(15);
      endcase
      calm <= (phase == 6);
      write_rule_count(SRX_COUNT_W'(count));
      active = (count > SRX_NUM_RULES) ? SRX_NUM_RULES : count;

      // a small pool of match symbols gives hits and duplicate matches
      for (int i = 0; i < 4; i++) sym_pool[i] = SRX_SYM_W'($urandom);
      if ($urandom_range(2) == 0) sym_pool[0] = 16'h0000;
      if ($urandom_range(2) == 0) sym_pool[1] = 16'hFFFF;

      for (int r = 0; r < active; r++)
        if (!rule_ready[r] || $urandom_range(3) == 0) load_rule(r);

      // hold the receiver off while the stream keeps coming
      if (phase == 2) squeeze <= 1'b1;

      repeat ($urandom_range(30, 12)) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          noise_item(active);
        end else begin
          if (pick < 62 && active > 0) sym = rule_match[$urandom_range(active - 1)];
          else if (pick < 80) sym = sym_pool[$urandom_range(3)];
          else sym = SRX_SYM_W'($urandom);
          send_item(CMD_REWRITE, SRX_RIDX_W'($urandom), SRX_POS_W'($urandom), sym,
                    SRX_LEN_W'($urandom));
        end
      end
      phase++;
    end
    settle();

    if (checker_errors == 0 && open_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/srx_pkg.sv
design/srx_ram.sv
design/symbol_rewrite_expander.sv
tb/sv/srx_emit_checker.sv
tb/sv/tb_symbol_rewrite_expander.sv
